FILE: rtl/tnls_pkg.sv
package tnls_pkg;

  localparam int COORD_W     = 16;
  localparam int SLOT_W      = 6;
  localparam int CFG_W       = 7;
  localparam int FOUND_W     = 2;
  localparam int OUT_SLOTS   = 3;
  // |dx| <= 65535, so each square fits 32 bits and the sum of three fits 34.
  localparam int ABS_W       = 16;
  localparam int SQ_W        = 32;
  localparam int DIST_W      = 34;
  localparam int IN_TDATA_W  = 56;
  localparam int OUT_TDATA_W = 24;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef struct packed {
    logic write;
    logic start;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic few_lights;
    logic last;
    logic pipe_busy;
    logic out_free;
  } dp_status_t;

endpackage

FILE: rtl/tnls_ctrl.sv
module tnls_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_action,
  output logic                   in_ready,
  input  tnls_pkg::dp_status_t   status,
  output tnls_pkg::ctrl_cmd_t    cmd
);
  import tnls_pkg::*;

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_SCAN   = 2'd1;
  localparam logic [1:0] ST_DRAIN  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;
  logic       accept;

  assign in_ready = (state == ST_IDLE);
  assign accept   = in_valid && in_ready;

  always_comb begin
    state_next = state;
    cmd        = '0;
    case (state)
      ST_IDLE: begin
        cmd.write = accept && (in_action == ACT_WRITE);
        cmd.start = accept && (in_action == ACT_QUERY);
        if (cmd.start) begin
          state_next = status.few_lights ? ST_FINISH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.issue = 1'b1;
        if (status.last) begin
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!status.pipe_busy) begin
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        // The result waits here until the output register can take it.
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

FILE: rtl/tnls_datapath.sv
module tnls_datapath #(
  parameter int MAX_LIGHTS    = 64,
  parameter int NEAREST_COUNT = 3
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_wr_en,
  input  logic [tnls_pkg::CFG_W-1:0]          cfg_wr_data,
  input  logic [tnls_pkg::SLOT_W-1:0]         light_slot,
  input  logic signed [tnls_pkg::COORD_W-1:0] coord_x,
  input  logic signed [tnls_pkg::COORD_W-1:0] coord_y,
  input  logic signed [tnls_pkg::COORD_W-1:0] coord_z,
  input  tnls_pkg::ctrl_cmd_t                 cmd,
  output tnls_pkg::dp_status_t                status,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [tnls_pkg::FOUND_W-1:0]        found_count,
  output logic [tnls_pkg::SLOT_W-1:0]         first_light,
  output logic [tnls_pkg::SLOT_W-1:0]         second_light,
  output logic [tnls_pkg::SLOT_W-1:0]         third_light
);
  import tnls_pkg::*;

  localparam int ADDR_W      = $clog2(MAX_LIGHTS);
  localparam int CNT_W       = $clog2(MAX_LIGHTS + 1);
  localparam int CMP_W       = (CNT_W > CFG_W) ? CNT_W : CFG_W;
  localparam int FOUND_SRCH  = (NEAREST_COUNT > OUT_SLOTS) ? OUT_SLOTS : NEAREST_COUNT;
  localparam int ENTRY_W     = 3 * COORD_W;

  // Configuration register and query context
  logic [CFG_W-1:0]   light_count;
  logic [CNT_W-1:0]   count_live;
  logic [CNT_W-1:0]   count_q;
  logic               small_q;
  logic [COORD_W-1:0] vx, vy, vz;
  logic [CNT_W-1:0]   ctr;

  always_ff @(posedge clk) begin
    if (rst) begin
      light_count <= '0;
    end else if (cfg_wr_en) begin
      light_count <= cfg_wr_data;
    end
  end

  assign count_live = (CMP_W'(light_count) > CMP_W'(MAX_LIGHTS)) ? CNT_W'(MAX_LIGHTS)
                                                                   : CNT_W'(light_count);

  assign status.few_lights = (CMP_W'(count_live) <= CMP_W'(NEAREST_COUNT));
  assign status.last       = (ctr == (count_q - CNT_W'(1)));
  assign status.out_free   = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      count_q <= count_live;
      small_q <= status.few_lights;
      vx      <= coord_x;
      vy      <= coord_y;
      vz      <= coord_z;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ctr <= '0;
    end else if (cmd.start) begin
      ctr <= '0;
    end else if (cmd.issue) begin
      ctr <= ctr + CNT_W'(1);
    end
  end

  // Light table: one write port for write transactions, one registered read port for the scan.
  logic [ENTRY_W-1:0] mem [MAX_LIGHTS];
  logic [ENTRY_W-1:0] rd_q;

  always_ff @(posedge clk) begin
    if (cmd.write && (int'(light_slot) < MAX_LIGHTS)) begin
      mem[ADDR_W'(light_slot)] <= {coord_z, coord_y, coord_x};
    end
    rd_q <= mem[ctr[ADDR_W-1:0]];
  end

  // Distance pipeline: read, absolute differences, squares, sum.
  logic              s1_valid, s2_valid, s3_valid, s4_valid;
  logic [ADDR_W-1:0] s1_slot, s2_slot, s3_slot, s4_slot;
  logic [COORD_W:0]  dx, dy, dz;
  logic [COORD_W:0]  mx, my, mz;
  logic [ABS_W-1:0]  ax, ay, az;
  logic [SQ_W-1:0]   sqx, sqy, sqz;
  logic [DIST_W-1:0] s4_dist;

  assign dx = {vx[COORD_W-1], vx} - {rd_q[COORD_W-1], rd_q[COORD_W-1:0]};
  assign dy = {vy[COORD_W-1], vy} - {rd_q[2*COORD_W-1], rd_q[2*COORD_W-1:COORD_W]};
  assign dz = {vz[COORD_W-1], vz} - {rd_q[3*COORD_W-1], rd_q[3*COORD_W-1:2*COORD_W]};
  assign mx = dx[COORD_W] ? ((COORD_W + 1)'(0) - dx) : dx;
  assign my = dy[COORD_W] ? ((COORD_W + 1)'(0) - dy) : dy;
  assign mz = dz[COORD_W] ? ((COORD_W + 1)'(0) - dz) : dz;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else begin
      s1_valid <= cmd.issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    s1_slot <= ctr[ADDR_W-1:0];
    s2_slot <= s1_slot;
    s3_slot <= s2_slot;
    s4_slot <= s3_slot;
    ax      <= mx[ABS_W-1:0];
    ay      <= my[ABS_W-1:0];
    az      <= mz[ABS_W-1:0];
    sqx     <= ax * ax;
    sqy     <= ay * ay;
    sqz     <= az * az;
    s4_dist <= DIST_W'(sqx) + DIST_W'(sqy) + DIST_W'(sqz);
  end

  assign status.pipe_busy = s1_valid || s2_valid || s3_valid || s4_valid;

  // Sorted best list. The list is ordered and its valid entries form a prefix, so the
  // "goes here or earlier" flags are monotonic and the insert point is the first one set.
  logic [DIST_W-1:0] best_distance [NEAREST_COUNT];
  logic [ADDR_W-1:0] best_slot     [NEAREST_COUNT];
  logic              best_valid    [NEAREST_COUNT];
  logic              lt            [NEAREST_COUNT];
  logic              first         [NEAREST_COUNT];

  always_comb begin
    for (int j = 0; j < NEAREST_COUNT; j++) begin
      lt[j] = !best_valid[j] || (s4_dist < best_distance[j]);
    end
    first[0] = lt[0];
    for (int j = 1; j < NEAREST_COUNT; j++) begin
      first[j] = lt[j] && !lt[j-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < NEAREST_COUNT; j++) begin
        best_valid[j] <= 1'b0;
      end
    end else if (cmd.start) begin
      for (int j = 0; j < NEAREST_COUNT; j++) begin
        best_valid[j] <= 1'b0;
      end
    end else if (s4_valid) begin
      if (lt[0]) begin
        best_valid[0] <= 1'b1;
      end
      for (int j = 1; j < NEAREST_COUNT; j++) begin
        if (first[j]) begin
          best_valid[j] <= 1'b1;
        end else if (lt[j]) begin
          best_valid[j] <= best_valid[j-1];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s4_valid) begin
      if (lt[0]) begin
        best_distance[0] <= s4_dist;
        best_slot[0]     <= s4_slot;
      end
      for (int j = 1; j < NEAREST_COUNT; j++) begin
        if (first[j]) begin
          best_distance[j] <= s4_dist;
          best_slot[j]     <= s4_slot;
        end else if (lt[j]) begin
          best_distance[j] <= best_distance[j-1];
          best_slot[j]     <= best_slot[j-1];
        end
      end
    end
  end

  // Result formation and output register
  logic [SLOT_W-1:0]  srch_idx [OUT_SLOTS];
  logic [SLOT_W-1:0]  res_idx  [OUT_SLOTS];
  logic [FOUND_W-1:0] res_found;

  for (genvar i = 0; i < OUT_SLOTS; i++) begin : g_srch
    if (i < NEAREST_COUNT) begin : g_used
      assign srch_idx[i] = SLOT_W'(best_slot[i]);
    end else begin : g_unused
      assign srch_idx[i] = '0;
    end
  end

  always_comb begin
    if (small_q) begin
      res_found = (count_q > CNT_W'(OUT_SLOTS)) ? FOUND_W'(OUT_SLOTS) : FOUND_W'(count_q);
      for (int i = 0; i < OUT_SLOTS; i++) begin
        res_idx[i] = (CNT_W'(i) < count_q) ? SLOT_W'(i) : '0;
      end
    end else begin
      res_found = FOUND_W'(FOUND_SRCH);
      for (int i = 0; i < OUT_SLOTS; i++) begin
        res_idx[i] = srch_idx[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      found_count  <= res_found;
      first_light  <= res_idx[0];
      second_light <= res_idx[1];
      third_light  <= res_idx[2];
    end
  end

endmodule

FILE: rtl/three_nearest_light_select_unit.sv
// Write transactions can follow back to back and produce no result.
// A query with light_count at or below NEAREST_COUNT skips the scan and goes straight to
// the result. Otherwise the scan reads one stored light per cycle over N slots (light_count
// capped at MAX_LIGHTS), then drains the distance pipeline and loads the result; the next
// item is taken only after the result is loaded.
// A full output register stalls the result and the input. rst is synchronous, active high.
module three_nearest_light_select_unit #(
  parameter int MAX_LIGHTS    = 64,
  parameter int NEAREST_COUNT = 3
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_wr_en,
  input  logic [tnls_pkg::CFG_W-1:0]           cfg_wr_data,
  input  logic                                 s_axis_tvalid,
  output logic                                 s_axis_tready,
  // light_slot[5:0], coord_x[21:6], coord_y[37:22], coord_z[53:38], zero pad
  input  logic [tnls_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
  // action[0]
  input  logic                                 s_axis_tuser,
  output logic                                 m_axis_tvalid,
  input  logic                                 m_axis_tready,
  // found_count[1:0], first_light[7:2], second_light[13:8], third_light[19:14], zero pad
  output logic [tnls_pkg::OUT_TDATA_W-1:0]     m_axis_tdata
);
  import tnls_pkg::*;

  ctrl_cmd_t          cmd;
  dp_status_t         status;
  logic [FOUND_W-1:0] found_count;
  logic [SLOT_W-1:0]  first_light, second_light, third_light;

  tnls_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_action (s_axis_tuser),
    .in_ready  (s_axis_tready),
    .status    (status),
    .cmd       (cmd)
  );

  tnls_datapath #(
    .MAX_LIGHTS    (MAX_LIGHTS),
    .NEAREST_COUNT (NEAREST_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_wr_en    (cfg_wr_en),
    .cfg_wr_data  (cfg_wr_data),
    .light_slot   (s_axis_tdata[SLOT_W-1:0]),
    .coord_x      (s_axis_tdata[SLOT_W +: COORD_W]),
    .coord_y      (s_axis_tdata[SLOT_W + COORD_W +: COORD_W]),
    .coord_z      (s_axis_tdata[SLOT_W + 2*COORD_W +: COORD_W]),
    .cmd          (cmd),
    .status       (status),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .found_count  (found_count),
    .first_light  (first_light),
    .second_light (second_light),
    .third_light  (third_light)
  );

  assign m_axis_tdata = {4'b0000, third_light, second_light, first_light, found_count};

endmodule
